@@ rtl/core/xst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xst_pkg
// Shared types and constants of the XML subset tokenizer: token kinds,
// character codes and the layout of one result beat.
// ----------------------------------------------------------------------------
package xst_pkg;

    localparam int LINE_BITS_DEFAULT = 32;
    localparam int LINE_OUT_BITS     = 32;

    typedef enum logic [2:0] {
        TOK_TEXT  = 3'd0,
        TOK_OPEN  = 3'd1,
        TOK_CLOSE = 3'd2,
        TOK_ANAME = 3'd3,
        TOK_AVAL  = 3'd4,
        TOK_EMPTY = 3'd5,
        TOK_END   = 3'd6,
        TOK_ERROR = 3'd7
    } token_kind_t;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_QMARK  = 8'h3F;

    typedef struct packed {
        token_kind_t               kind;
        logic [7:0]                content;
        logic                      has_content;
        logic                      done;
        logic                      last;
        logic [LINE_OUT_BITS-1:0]  line;
    } res_t;

    function automatic res_t mk_res(input token_kind_t kind, input logic [7:0] content,
                                    input logic has, input logic done,
                                    input logic [LINE_OUT_BITS-1:0] line);
        res_t r;
        r.kind        = kind;
        r.content     = has ? content : 8'h00;
        r.has_content = has;
        r.done        = done;
        r.last        = 1'b0;
        r.line        = line;
        return r;
    endfunction

endpackage

@@ rtl/core/xml_subset_tokenizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_subset_tokenizer
// Streaming tokenizer for a simplified XML subset, one document byte per beat.
// ----------------------------------------------------------------------------
// Each input beat is one document byte, or the end of the document when
// s_tlast is set (the byte is then ignored). The parser decides the tokens of
// a beat in the cycle it is accepted and places its zero, one or two result
// beats into a three-entry output queue. The input is ready while the queue
// holds at most one beat, so bytes that cause at most one result stream at one
// beat per cycle under a ready sink; an end marker that causes two results
// costs two output beats. m_tlast marks the final result of an input beat.
// An error drops all bytes up to the end marker, and every end marker returns
// the parser to its reset state.
// ----------------------------------------------------------------------------
module xml_subset_tokenizer
    import xst_pkg::*;
#(
    parameter int LINE_BITS = LINE_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_marker
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] content_byte, [39:8] line_number
    output logic [4:0]  m_tuser,   // [2:0] token_kind, [3] has_content, [4] token_done
    output logic        m_tlast    // last_result
);

    typedef enum logic [3:0] {
        PH_TEXT, PH_LT, PH_BANG, PH_DASH, PH_COMMENT, PH_PI, PH_DTD, PH_TAGNAME,
        PH_TAG, PH_TAG_FRESH, PH_SLASH, PH_ATTRNAME, PH_VALSTART, PH_UVALUE,
        PH_QVALUE, PH_ERROR
    } phase_t;

    typedef struct packed {
        phase_t phase;
        logic   emit;
        res_t   res;
    } tag_step_t;

    localparam int EXT_W = (LINE_BITS > LINE_OUT_BITS) ? LINE_BITS : LINE_OUT_BITS;

    phase_t                 phase_reg, phase_next;
    logic                   closing_reg, closing_next;
    logic                   dquote_reg, dquote_next;
    logic [1:0]             match_reg, match_next;
    logic                   open_reg, open_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [1:0]             count_reg, count_next;
    res_t                   q_reg [3];
    res_t                   q_next [3];

    res_t                   res [2];
    logic [1:0]             res_n;
    logic [1:0]             base;
    tag_step_t              ts;
    logic [EXT_W-1:0]       line_ext;
    logic [LINE_OUT_BITS-1:0] line_out;
    logic [7:0]             b;
    logic                   s_fire;
    logic                   m_fire;
    token_kind_t            name_kind;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) || (c == CH_CR);
    endfunction

    function automatic tag_step_t tag_step(input logic [7:0] c,
                                           input logic [LINE_OUT_BITS-1:0] line);
        tag_step_t t;
        t.phase = PH_TAG;
        t.emit  = 1'b0;
        t.res   = mk_res(TOK_ERROR, 8'h00, 1'b0, 1'b1, line);
        if (is_ws(c)) begin
            t.phase = PH_TAG;
        end else if (c == CH_GT) begin
            t.phase = PH_TEXT;
        end else if (c == CH_SLASH) begin
            t.phase = PH_SLASH;
        end else if (c == CH_EQ) begin
            t.phase = PH_ERROR;
            t.emit  = 1'b1;
        end else begin
            t.phase = PH_ATTRNAME;
            t.emit  = 1'b1;
            t.res   = mk_res(TOK_ANAME, c, 1'b1, 1'b0, line);
        end
        return t;
    endfunction

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;
    assign b      = s_tdata;

    assign line_ext  = EXT_W'(line_reg);
    assign line_out  = (line_ext > EXT_W'({LINE_OUT_BITS{1'b1}})) ? '1
                                                                  : line_ext[LINE_OUT_BITS-1:0];
    assign name_kind = closing_reg ? TOK_CLOSE : TOK_OPEN;
    assign ts        = tag_step(b, line_out);

    always_comb begin
        phase_next   = phase_reg;
        closing_next = closing_reg;
        dquote_next  = dquote_reg;
        match_next   = match_reg;
        open_next    = open_reg;
        line_next    = line_reg;
        res[0]       = mk_res(TOK_TEXT, 8'h00, 1'b0, 1'b0, line_out);
        res[1]       = mk_res(TOK_TEXT, 8'h00, 1'b0, 1'b0, line_out);
        res_n        = 2'd0;

        if (s_fire && s_tlast) begin
            case (phase_reg)
                PH_TEXT: begin
                    if (open_reg) begin
                        res[res_n[0]] = mk_res(TOK_TEXT, 8'h00, 1'b0, 1'b1, line_out);
                        res_n = res_n + 2'd1;
                    end
                    res[res_n[0]] = mk_res(TOK_END, 8'h00, 1'b0, 1'b1, line_out);
                    res_n = res_n + 2'd1;
                end
                PH_TAG_FRESH: begin
                    res[0] = mk_res(TOK_END, 8'h00, 1'b0, 1'b1, line_out);
                    res_n  = 2'd1;
                end
                PH_ATTRNAME: begin
                    res[0] = mk_res(TOK_ANAME, 8'h00, 1'b0, 1'b1, line_out);
                    res[1] = mk_res(TOK_END, 8'h00, 1'b0, 1'b1, line_out);
                    res_n  = 2'd2;
                end
                PH_ERROR: begin
                    res_n = 2'd0;
                end
                default: begin
                    res[0] = mk_res(TOK_ERROR, 8'h00, 1'b0, 1'b1, line_out);
                    res_n  = 2'd1;
                end
            endcase
            phase_next   = PH_TEXT;
            closing_next = 1'b0;
            dquote_next  = 1'b0;
            match_next   = 2'd0;
            open_next    = 1'b0;
            line_next    = LINE_BITS'(1);
        end else if (s_fire) begin
            if (phase_reg != PH_ERROR && b == CH_NL && line_reg != '1) begin
                line_next = line_reg + LINE_BITS'(1);
            end
            case (phase_reg)
                PH_TEXT: begin
                    if (b == CH_LT) begin
                        if (open_reg) begin
                            res[0] = mk_res(TOK_TEXT, 8'h00, 1'b0, 1'b1, line_out);
                            res_n  = 2'd1;
                        end
                        open_next  = 1'b0;
                        phase_next = PH_LT;
                    end else begin
                        res[0]    = mk_res(TOK_TEXT, b, 1'b1, 1'b0, line_out);
                        res_n     = 2'd1;
                        open_next = 1'b1;
                    end
                end
                PH_LT, PH_TAGNAME: begin
                    if (phase_reg == PH_LT && b == CH_BANG) begin
                        phase_next = PH_BANG;
                    end else if (phase_reg == PH_LT && b == CH_QMARK) begin
                        match_next = 2'd0;
                        phase_next = PH_PI;
                    end else if (phase_reg == PH_LT && b == CH_SLASH) begin
                        closing_next = 1'b1;
                        phase_next   = PH_TAGNAME;
                    end else begin
                        if (phase_reg == PH_LT) begin
                            closing_next = 1'b0;
                        end
                        if (is_ws(b) || b == CH_SLASH || b == CH_GT) begin
                            res[0]     = mk_res((phase_reg == PH_LT) ? TOK_OPEN : name_kind,
                                                8'h00, 1'b0, 1'b1, line_out);
                            res_n      = 2'd1;
                            phase_next = ts.phase;
                        end else begin
                            res[0]     = mk_res((phase_reg == PH_LT) ? TOK_OPEN : name_kind,
                                                b, 1'b1, 1'b0, line_out);
                            res_n      = 2'd1;
                            phase_next = PH_TAGNAME;
                        end
                    end
                end
                PH_BANG, PH_DASH: begin
                    if (b == CH_GT) begin
                        phase_next = PH_TEXT;
                    end else if (b == CH_DASH && phase_reg == PH_BANG) begin
                        phase_next = PH_DASH;
                    end else if (b == CH_DASH) begin
                        match_next = 2'd0;
                        phase_next = PH_COMMENT;
                    end else begin
                        phase_next = PH_DTD;
                    end
                end
                PH_COMMENT: begin
                    if (match_reg[1] && b == CH_GT) begin
                        match_next = 2'd0;
                        phase_next = PH_TEXT;
                    end else if (b == CH_DASH) begin
                        match_next = (match_reg != 2'd0) ? 2'd2 : 2'd1;
                    end else begin
                        match_next = 2'd0;
                    end
                end
                PH_PI: begin
                    if (match_reg != 2'd0 && b == CH_GT) begin
                        match_next = 2'd0;
                        phase_next = PH_TEXT;
                    end else begin
                        match_next = (b == CH_QMARK) ? 2'd1 : 2'd0;
                    end
                end
                PH_DTD: begin
                    if (b == CH_GT) begin
                        phase_next = PH_TEXT;
                    end
                end
                PH_TAG, PH_TAG_FRESH: begin
                    phase_next = ts.phase;
                    if (ts.emit) begin
                        res[0] = ts.res;
                        res_n  = 2'd1;
                    end
                end
                PH_SLASH: begin
                    if (b == CH_GT) begin
                        res[0]     = mk_res(TOK_EMPTY, 8'h00, 1'b0, 1'b1, line_out);
                        phase_next = PH_TEXT;
                    end else begin
                        res[0]     = mk_res(TOK_ERROR, 8'h00, 1'b0, 1'b1, line_out);
                        phase_next = PH_ERROR;
                    end
                    res_n = 2'd1;
                end
                PH_ATTRNAME: begin
                    if (is_ws(b) || b == CH_EQ || b == CH_SLASH || b == CH_GT) begin
                        res[0] = mk_res(TOK_ANAME, 8'h00, 1'b0, 1'b1, line_out);
                        res_n  = 2'd1;
                        if (b == CH_EQ) begin
                            phase_next = PH_VALSTART;
                        end else begin
                            phase_next = ts.phase;
                        end
                    end else begin
                        res[0] = mk_res(TOK_ANAME, b, 1'b1, 1'b0, line_out);
                        res_n  = 2'd1;
                    end
                end
                PH_VALSTART, PH_UVALUE: begin
                    if (phase_reg == PH_VALSTART && (b == CH_DQUOTE || b == CH_SQUOTE)) begin
                        dquote_next = (b == CH_DQUOTE);
                        phase_next  = PH_QVALUE;
                    end else if (is_ws(b) || b == CH_GT) begin
                        res[0]     = mk_res(TOK_AVAL, 8'h00, 1'b0, 1'b1, line_out);
                        res_n      = 2'd1;
                        phase_next = ts.phase;
                    end else begin
                        res[0]     = mk_res(TOK_AVAL, b, 1'b1, 1'b0, line_out);
                        res_n      = 2'd1;
                        phase_next = PH_UVALUE;
                    end
                end
                PH_QVALUE: begin
                    if (b == (dquote_reg ? CH_DQUOTE : CH_SQUOTE)) begin
                        res[0]     = mk_res(TOK_AVAL, 8'h00, 1'b0, 1'b1, line_out);
                        phase_next = PH_TAG_FRESH;
                    end else begin
                        res[0] = mk_res(TOK_AVAL, b, 1'b1, 1'b0, line_out);
                    end
                    res_n = 2'd1;
                end
                default: begin
                    res_n = 2'd0;
                end
            endcase
        end

        if (res_n == 2'd2) begin
            res[1].last = 1'b1;
        end else if (res_n == 2'd1) begin
            res[0].last = 1'b1;
        end
    end

    always_comb begin
        base = count_reg - {1'b0, m_fire};
        for (int i = 0; i < 3; i++) begin
            q_next[i] = q_reg[i];
        end
        if (m_fire) begin
            q_next[0] = q_reg[1];
            q_next[1] = q_reg[2];
        end
        if (res_n != 2'd0) begin
            q_next[base] = res[0];
        end
        if (res_n == 2'd2) begin
            q_next[base + 2'd1] = res[1];
        end
        count_next = base + res_n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_TEXT;
            closing_reg <= 1'b0;
            dquote_reg  <= 1'b0;
            match_reg   <= 2'd0;
            open_reg    <= 1'b0;
            line_reg    <= LINE_BITS'(1);
            count_reg   <= 2'd0;
        end else begin
            phase_reg   <= phase_next;
            closing_reg <= closing_next;
            dquote_reg  <= dquote_next;
            match_reg   <= match_next;
            open_reg    <= open_next;
            line_reg    <= line_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

    assign s_tready = aresetn && !count_reg[1];
    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = {q_reg[0].line, q_reg[0].content};
    assign m_tuser  = {q_reg[0].done, q_reg[0].has_content, q_reg[0].kind};
    assign m_tlast  = q_reg[0].last;

endmodule

@@ rtl/core/xst_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xst_checker
// Port-level checks of the XML subset tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module xst_checker
    import xst_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [4:0]  m_tuser,
    input logic        m_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("Result beat changed while stalled.");

    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[2:0] == TOK_END || m_tuser[2:0] == TOK_ERROR
                     || m_tuser[2:0] == TOK_EMPTY) |-> m_tuser[4] && !m_tuser[3])
        else $error("Single-beat token without done mark or with content.");

    a_done_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[4] |-> !m_tuser[3] && m_tdata[7:0] == 8'h00)
        else $error("Token end beat carries a byte.");

    a_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[39:8] != 32'd0)
        else $error("Line number is zero.");

    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[2:0] == TOK_END || m_tuser[2:0] == TOK_ERROR) |-> m_tlast)
        else $error("End or error token is not the final result of its beat.");

endmodule

bind xml_subset_tokenizer xst_checker u_xst_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the XML subset tokenizer.
// ----------------------------------------------------------------------------
// A short directed prologue covers byte extremes, every token kind, empty tag
// names, a stray '=', a slash that does not close a tag, end markers in text
// and while bytes are dropped after an error. Random documents follow:
// mostly well-formed tags, attributes, text, comments, processing
// instructions and declarations, with noise bytes and documents cut off at
// random points. The sender runs in bursts with gaps and the sink stalls in
// changing patterns. A scanner model in the bench predicts each result beat,
// and the monitor compares the beats field by field in order.
// ----------------------------------------------------------------------------
module testbench;
    import xst_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int RANDOM_BEATS   = 700;
    localparam int SHOWN_ERRORS   = 40;

    typedef enum logic [3:0] {
        SCAN_TEXT, SCAN_LT, SCAN_BANG, SCAN_DASH, SCAN_COMMENT, SCAN_PI, SCAN_DECL,
        SCAN_NAME, SCAN_TAG, SCAN_AFTER_QUOTE, SCAN_SLASH, SCAN_ATTR, SCAN_VAL_START,
        SCAN_UNQUOTED, SCAN_QUOTED, SCAN_DROP
    } scan_state_t;

    typedef enum logic [1:0] {
        SINK_OPEN, SINK_RANDOM, SINK_SPARSE, SINK_BURSTY
    } sink_mode_t;

    typedef struct packed {
        logic [7:0] data;
        logic       eod;
    } doc_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;   // [7:0] content_byte, [39:8] line_number
    logic [4:0]  m_tuser;   // [2:0] token_kind, [3] has_content, [4] token_done
    logic        m_tlast;

    xml_subset_tokenizer uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    doc_beat_t   pending_beats[$];
    logic [7:0]  doc_q[$];
    res_t        beat_tokens[$];
    res_t        expected_tokens[$];

    scan_state_t scan_st;
    logic        in_close_tag;
    logic        dq_value;
    logic [1:0]  dash_run;
    logic        text_pending;
    logic [31:0] line_cnt;
    logic [31:0] line_at_byte;

    int          n_items;
    int          beats_in;
    int          results_out;
    int          errors;
    int          idle_cycles;
    int          doc_bytes;
    int          doc_count;
    int          kind_seen[8];

    logic        in_flight;
    logic        in_taken;
    int          burst_left;
    int          gap_left;
    sink_mode_t  sink_mode;
    int          mode_left;
    int          stall_left;
    logic [2:0]  sink_tick;

    function automatic logic is_ws(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_NL || b == CH_CR;
    endfunction

    task automatic reset_scanner();
        scan_st      = SCAN_TEXT;
        in_close_tag = 1'b0;
        dq_value     = 1'b0;
        dash_run     = 2'd0;
        text_pending = 1'b0;
        line_cnt     = 32'd1;
        line_at_byte = 32'd1;
    endtask

    task automatic put_token(input token_kind_t k, input logic [7:0] c, input logic has,
                             input logic done);
        res_t r;
        r.kind        = k;
        r.content     = has ? c : 8'h00;
        r.has_content = has;
        r.done        = done;
        r.last        = 1'b0;
        r.line        = line_at_byte;
        beat_tokens.push_back(r);
    endtask

    task automatic tag_step(input logic [7:0] b);
        if (is_ws(b)) begin
            scan_st = SCAN_TAG;
        end else if (b == CH_GT) begin
            scan_st = SCAN_TEXT;
        end else if (b == CH_SLASH) begin
            scan_st = SCAN_SLASH;
        end else if (b == CH_EQ) begin
            put_token(TOK_ERROR, 8'h00, 1'b0, 1'b1);
            scan_st = SCAN_DROP;
        end else begin
            put_token(TOK_ANAME, b, 1'b1, 1'b0);
            scan_st = SCAN_ATTR;
        end
    endtask

    task automatic tag_name_step(input logic [7:0] b);
        token_kind_t k;
        k = in_close_tag ? TOK_CLOSE : TOK_OPEN;
        if (is_ws(b) || b == CH_SLASH || b == CH_GT) begin
            put_token(k, 8'h00, 1'b0, 1'b1);
            tag_step(b);
        end else begin
            scan_st = SCAN_NAME;
            put_token(k, b, 1'b1, 1'b0);
        end
    endtask

    task automatic predict_tokens(input logic [7:0] b, input logic eod);
        res_t r;
        beat_tokens.delete();
        line_at_byte = line_cnt;
        if (eod) begin
            doc_count++;
            case (scan_st)
                SCAN_TEXT: begin
                    if (text_pending)
                        put_token(TOK_TEXT, 8'h00, 1'b0, 1'b1);
                    put_token(TOK_END, 8'h00, 1'b0, 1'b1);
                end
                SCAN_AFTER_QUOTE: put_token(TOK_END, 8'h00, 1'b0, 1'b1);
                SCAN_ATTR: begin
                    put_token(TOK_ANAME, 8'h00, 1'b0, 1'b1);
                    put_token(TOK_END, 8'h00, 1'b0, 1'b1);
                end
                SCAN_DROP: ;
                default: put_token(TOK_ERROR, 8'h00, 1'b0, 1'b1);
            endcase
            reset_scanner();
        end else begin
            doc_bytes++;
            if (scan_st != SCAN_DROP && b == CH_NL && line_cnt != 32'hFFFF_FFFF)
                line_cnt++;
            case (scan_st)
                SCAN_TEXT: begin
                    if (b == CH_LT) begin
                        if (text_pending)
                            put_token(TOK_TEXT, 8'h00, 1'b0, 1'b1);
                        text_pending = 1'b0;
                        scan_st = SCAN_LT;
                    end else begin
                        put_token(TOK_TEXT, b, 1'b1, 1'b0);
                        text_pending = 1'b1;
                    end
                end
                SCAN_LT: begin
                    if (b == CH_BANG) begin
                        scan_st = SCAN_BANG;
                    end else if (b == CH_QMARK) begin
                        dash_run = 2'd0;
                        scan_st = SCAN_PI;
                    end else if (b == CH_SLASH) begin
                        in_close_tag = 1'b1;
                        scan_st = SCAN_NAME;
                    end else begin
                        in_close_tag = 1'b0;
                        tag_name_step(b);
                    end
                end
                SCAN_NAME: tag_name_step(b);
                SCAN_BANG, SCAN_DASH: begin
                    if (b == CH_GT) begin
                        scan_st = SCAN_TEXT;
                    end else if (b == CH_DASH && scan_st == SCAN_BANG) begin
                        scan_st = SCAN_DASH;
                    end else if (b == CH_DASH) begin
                        dash_run = 2'd0;
                        scan_st = SCAN_COMMENT;
                    end else begin
                        scan_st = SCAN_DECL;
                    end
                end
                SCAN_COMMENT: begin
                    if (dash_run >= 2'd2 && b == CH_GT) begin
                        dash_run = 2'd0;
                        scan_st = SCAN_TEXT;
                    end else if (b == CH_DASH) begin
                        dash_run = (dash_run >= 2'd1) ? 2'd2 : 2'd1;
                    end else begin
                        dash_run = 2'd0;
                    end
                end
                SCAN_PI: begin
                    if (dash_run != 2'd0 && b == CH_GT) begin
                        dash_run = 2'd0;
                        scan_st = SCAN_TEXT;
                    end else begin
                        dash_run = (b == CH_QMARK) ? 2'd1 : 2'd0;
                    end
                end
                SCAN_DECL: begin
                    if (b == CH_GT)
                        scan_st = SCAN_TEXT;
                end
                SCAN_TAG, SCAN_AFTER_QUOTE: tag_step(b);
                SCAN_SLASH: begin
                    if (b == CH_GT) begin
                        put_token(TOK_EMPTY, 8'h00, 1'b0, 1'b1);
                        scan_st = SCAN_TEXT;
                    end else begin
                        put_token(TOK_ERROR, 8'h00, 1'b0, 1'b1);
                        scan_st = SCAN_DROP;
                    end
                end
                SCAN_ATTR: begin
                    if (is_ws(b) || b == CH_EQ || b == CH_SLASH || b == CH_GT) begin
                        put_token(TOK_ANAME, 8'h00, 1'b0, 1'b1);
                        if (b == CH_EQ)
                            scan_st = SCAN_VAL_START;
                        else
                            tag_step(b);
                    end else begin
                        put_token(TOK_ANAME, b, 1'b1, 1'b0);
                    end
                end
                SCAN_VAL_START, SCAN_UNQUOTED: begin
                    if (scan_st == SCAN_VAL_START && (b == CH_DQUOTE || b == CH_SQUOTE)) begin
                        dq_value = (b == CH_DQUOTE);
                        scan_st = SCAN_QUOTED;
                    end else if (is_ws(b) || b == CH_GT) begin
                        put_token(TOK_AVAL, 8'h00, 1'b0, 1'b1);
                        tag_step(b);
                    end else begin
                        put_token(TOK_AVAL, b, 1'b1, 1'b0);
                        scan_st = SCAN_UNQUOTED;
                    end
                end
                SCAN_QUOTED: begin
                    if (b == (dq_value ? CH_DQUOTE : CH_SQUOTE)) begin
                        put_token(TOK_AVAL, 8'h00, 1'b0, 1'b1);
                        scan_st = SCAN_AFTER_QUOTE;
                    end else begin
                        put_token(TOK_AVAL, b, 1'b1, 1'b0);
                    end
                end
                default: ;
            endcase
        end
        if (beat_tokens.size() != 0) begin
            r = beat_tokens.pop_back();
            r.last = 1'b1;
            beat_tokens.push_back(r);
        end
        while (beat_tokens.size() != 0)
            expected_tokens.push_back(beat_tokens.pop_front());
    endtask

    function automatic logic [7:0] rand_ws();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_NL;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        case ($urandom_range(0, 7))
            0: b = CH_NL;
            1: b = 8'($urandom_range(0, 255));
            2: b = CH_SPACE;
            default: b = 8'($urandom_range(8'h61, 8'h7A));
        endcase
        return b;
    endfunction

    function automatic logic [7:0] rand_name_char();
        logic [7:0] b;
        if ($urandom_range(0, 7) == 0) begin
            do b = 8'($urandom_range(0, 255));
            while (is_ws(b) || b == CH_SLASH || b == CH_GT || b == CH_EQ);
        end else begin
            b = 8'($urandom_range(8'h61, 8'h7A));
        end
        return b;
    endfunction

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            doc_q.push_back(s[i]);
    endtask

    task automatic push_name(input int lo, input int hi);
        int n;
        n = $urandom_range(lo, hi);
        for (int i = 0; i < n; i++)
            doc_q.push_back(rand_name_char());
    endtask

    task automatic close_doc(input bit cut);
        int keep;
        doc_beat_t bt;
        keep = doc_q.size();
        if (cut && keep > 0)
            keep = $urandom_range(0, keep - 1);
        for (int i = 0; i < keep; i++) begin
            bt.data = doc_q[i];
            bt.eod  = 1'b0;
            pending_beats.push_back(bt);
        end
        bt.data = 8'($urandom_range(0, 255));
        bt.eod  = 1'b1;
        pending_beats.push_back(bt);
        doc_q.delete();
    endtask

    task automatic add_tag(input bit closing);
        int n_attr;
        logic [7:0] q;
        logic [7:0] b;
        doc_q.push_back(CH_LT);
        if (closing)
            doc_q.push_back(CH_SLASH);
        push_name(($urandom_range(0, 9) == 0) ? 0 : 1, 6);
        n_attr = closing ? 0 : $urandom_range(0, 3);
        for (int a = 0; a < n_attr; a++) begin
            doc_q.push_back(rand_ws());
            if ($urandom_range(0, 2) == 0)
                doc_q.push_back(rand_ws());
            push_name(1, 5);
            case ($urandom_range(0, 4))
                0: ;
                1, 2: begin
                    q = ($urandom_range(0, 1) != 0) ? CH_DQUOTE : CH_SQUOTE;
                    doc_q.push_back(CH_EQ);
                    doc_q.push_back(q);
                    repeat ($urandom_range(0, 6)) begin
                        do b = text_byte(); while (b == q);
                        doc_q.push_back(b);
                    end
                    doc_q.push_back(q);
                end
                3: begin
                    doc_q.push_back(CH_EQ);
                    repeat ($urandom_range(1, 4)) begin
                        do b = rand_name_char(); while (b == CH_DQUOTE || b == CH_SQUOTE);
                        doc_q.push_back(b);
                    end
                end
                default: doc_q.push_back(CH_EQ);
            endcase
        end
        if ($urandom_range(0, 2) == 0)
            doc_q.push_back(rand_ws());
        if (!closing && $urandom_range(0, 3) == 0)
            doc_q.push_back(CH_SLASH);
        doc_q.push_back(CH_GT);
    endtask

    task automatic random_document();
        logic [7:0] b;
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    repeat ($urandom_range(1, 8)) begin
                        do b = text_byte(); while (b == CH_LT);
                        doc_q.push_back(b);
                    end
                end
                2, 3, 4: add_tag(1'b0);
                5: add_tag(1'b1);
                6: begin
                    push_str("<!--");
                    repeat ($urandom_range(0, 8)) begin
                        case ($urandom_range(0, 3))
                            0, 1: doc_q.push_back(CH_DASH);
                            2: doc_q.push_back(CH_GT);
                            default: doc_q.push_back(text_byte());
                        endcase
                    end
                    push_str("-->");
                end
                7: begin
                    push_str("<?");
                    repeat ($urandom_range(0, 8)) begin
                        case ($urandom_range(0, 3))
                            0, 1: doc_q.push_back(CH_QMARK);
                            2: doc_q.push_back(CH_GT);
                            default: doc_q.push_back(text_byte());
                        endcase
                    end
                    push_str("?>");
                end
                8: begin
                    case ($urandom_range(0, 3))
                        0: begin
                            push_str("<!DOCTYPE ");
                            push_name(1, 5);
                            doc_q.push_back(CH_GT);
                        end
                        1: push_str("<!>");
                        2: push_str("<!-x>");
                        default: push_str("<!->");
                    endcase
                end
                default: begin
                    repeat ($urandom_range(1, 4))
                        doc_q.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end
        close_doc($urandom_range(0, 5) == 0);
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= SHOWN_ERRORS)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!in_flight || in_taken) begin
            in_taken  = 1'b0;
            in_flight = 1'b0;
            if (gap_left != 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_beats.size() != 0) begin
                s_tdata  <= pending_beats[0].data;
                s_tlast  <= pending_beats[0].eod;
                s_tvalid <= 1'b1;
                void'(pending_beats.pop_front());
                in_flight = 1'b1;
                if (burst_left == 0)
                    burst_left = $urandom_range(1, 40);
                burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                           : $urandom_range(0, 3);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                sink_mode = sink_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(32, 300);
            end
            mode_left--;
            sink_tick++;
            case (sink_mode)
                SINK_OPEN:   m_tready <= 1'b1;
                SINK_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
                SINK_SPARSE: m_tready <= (sink_tick == 3'd0);
                default: begin
                    if (stall_left != 0) begin
                        stall_left--;
                        m_tready <= 1'b0;
                    end else begin
                        m_tready <= 1'b1;
                        if ($urandom_range(0, 7) == 0)
                            stall_left = $urandom_range(1, 12);
                    end
                end
            endcase
        end
    end

    always @(posedge aclk) begin
        res_t want;
        logic s_fire;
        logic m_fire;
        if (aresetn) begin
            s_fire = s_tvalid && s_tready;
            m_fire = m_tvalid && m_tready;
            if (s_fire) begin
                predict_tokens(s_tdata, s_tlast);
                beats_in++;
                in_taken = 1'b1;
            end
            if (m_fire) begin
                results_out++;
                if (expected_tokens.size() == 0) begin
                    errors++;
                    if (errors <= SHOWN_ERRORS)
                        $display("%0t: unexpected result beat, tdata %0h tuser %0h tlast %0b",
                                 $time, m_tdata, m_tuser, m_tlast);
                end else begin
                    want = expected_tokens.pop_front();
                    kind_seen[want.kind]++;
                    check_field("token_kind", 32'(want.kind), 32'(m_tuser[2:0]));
                    check_field("content_byte", 32'(want.content), 32'(m_tdata[7:0]));
                    check_field("has_content", 32'(want.has_content), 32'(m_tuser[3]));
                    check_field("token_done", 32'(want.done), 32'(m_tuser[4]));
                    check_field("line_number", want.line, m_tdata[39:8]);
                    check_field("last_result", 32'(want.last), 32'(m_tlast));
                end
            end
            if (s_fire || m_fire)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles, %0d results still due",
                         $time, idle_cycles, expected_tokens.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        in_flight  = 1'b0;
        in_taken   = 1'b0;
        burst_left = 0;
        gap_left   = 0;
        sink_mode  = SINK_OPEN;
        mode_left  = 0;
        stall_left = 0;
        sink_tick  = 3'd0;
        reset_scanner();

        doc_q.push_back(8'h00);
        doc_q.push_back(8'hFF);
        doc_q.push_back(CH_NL);
        push_str("<a k=\"v\"/>");
        close_doc(1'b0);
        push_str("</>x");
        close_doc(1'b0);
        push_str("< =");
        close_doc(1'b0);
        push_str("<//q");
        close_doc(1'b0);
        n_items = pending_beats.size() + RANDOM_BEATS;
        while (pending_beats.size() < n_items)
            random_document();
        n_items = pending_beats.size();

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        wait (beats_in == n_items);
        while (expected_tokens.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("tb: %0d document bytes in %0d documents, %0d result beats checked",
                 doc_bytes, doc_count, results_out);
        $display("tb: text %0d open %0d close %0d attr %0d value %0d empty %0d end %0d err %0d",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
                 kind_seen[4], kind_seen[5], kind_seen[6], kind_seen[7]);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
